// ----- sv/dcs_pkg.sv -----
`default_nettype none
package dcs_pkg;
    localparam int ENTRIES_DEF = 16;
    localparam int MAX_FIRES = 16;

    typedef enum logic [2:0] {
        OP_SCHED_ABS = 3'd0,
        OP_SCHED_REL = 3'd1,
        OP_CANCEL    = 3'd2,
        OP_QUERY     = 3'd3,
        OP_TICK      = 3'd4
    } op_t;

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_RM_RD   = 14'b00000000000010,
        ST_RM_CHK  = 14'b00000000000100,
        ST_WR_SLOT = 14'b00000000001000,
        ST_IN_RD   = 14'b00000000010000,
        ST_IN_CHK  = 14'b00000000100000,
        ST_ACK     = 14'b00000001000000,
        ST_TK_RD   = 14'b00000010000000,
        ST_TK_CHK  = 14'b00000100000000,
        ST_FIRE    = 14'b00001000000000,
        ST_OUT     = 14'b00010000000000,
        ST_TK_NEXT = 14'b00100000000000,
        ST_RM_PRV  = 14'b01000000000000,
        ST_IN_LNK  = 14'b10000000000000
    } state_t;
endpackage
`default_nettype wire

// ----- sv/deadline_callout_scheduler.sv -----
// Channel  | Signals                                                  | Direction
// request  | valid, ready (out), operation, entry_index, time_value,  | in
//          | repeat_period                                            |
// result   | result_valid, result_ready (in), result_kind, slot_id,   | out
//          | slot_pending, fired_deadline, current_time, last         |
// A schedule unlinks, then does a sorted insert before its result.
// Cancel unlinks the slot; a query answers in the cycle after it is taken.
// A tick searches for each due slot in turn and ends with a closing search;
// each fire result goes out once the following search decides last.
// Reset clears head, time and queued flags; memories need no clearing pass.
// A result stalled by result_ready holds the sequencer before its next result; no request is taken meanwhile.
`default_nettype none
module deadline_callout_scheduler
    import dcs_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             ready,
    input  wire logic [2:0]  operation,
    input  wire logic [3:0]  entry_index,
    input  wire logic [63:0] time_value,
    input  wire logic [63:0] repeat_period,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             result_kind,
    output logic [3:0]       slot_id,
    output logic             slot_pending,
    output logic [63:0]      fired_deadline,
    output logic [63:0]      current_time,
    output logic             last
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = $clog2(ENTRIES + 1);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int FW = $clog2(MAX_FIRES + 1);
    localparam logic [LW-1:0] NIL = LW'(ENTRIES);

    // slot memories: deadline, period, next link
    logic [63:0]   dl_mem  [ENTRIES];
    logic [63:0]   per_mem [ENTRIES];
    logic [LW-1:0] nx_mem  [ENTRIES];

    logic [ENTRIES-1:0] queued_reg, queued_next;
    logic [ENTRIES-1:0] fired_reg, fired_next;
    logic [LW-1:0] head_reg, head_next;
    logic [63:0]   now_reg, now_next;
    state_t        st_reg, st_next;

    logic [2:0]    op_reg, op_next;
    logic [IW-1:0] s_reg, s_next;
    logic [63:0]   tv_reg, tv_next;
    logic [63:0]   per_reg, per_next;
    logic [63:0]   key_reg, key_next;
    logic [LW-1:0] cur_reg, cur_next;
    logic [LW-1:0] prv_reg, prv_next;
    logic [CW-1:0] stp_reg, stp_next;
    logic [FW-1:0] nf_reg, nf_next;
    logic [63:0]   fdl_reg, fdl_next;

    // memory read port (one address, registered data)
    logic [IW-1:0] rd_addr;
    logic [63:0]   rd_dl, rd_per;
    logic [LW-1:0] rd_nx;
    // memory write controls
    logic          we_dp, we_nx;
    logic [IW-1:0] wa_dp, wa_nx;
    logic [63:0]   wd_dl, wd_per;
    logic [LW-1:0] wd_nx;

    // output register
    logic          ov_reg, ov_next;
    logic          ok_reg, ok_next, op_pend_reg, op_pend_next, ol_reg, ol_next;
    logic [3:0]    oid_reg, oid_next;
    logic [63:0]   odl_reg, odl_next, ot_reg, ot_next;

    // release of the held fire result
    logic          emit_fire, emit_last;

    always_ff @(posedge clk)
    begin
        rd_dl  <= dl_mem[rd_addr];
        rd_per <= per_mem[rd_addr];
        rd_nx  <= nx_mem[rd_addr];
        if (we_dp)
        begin
            dl_mem[wa_dp]  <= wd_dl;
            per_mem[wa_dp] <= wd_per;
        end
        if (we_nx)
            nx_mem[wa_nx] <= wd_nx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            queued_reg <= '0;
            fired_reg  <= '0;
            head_reg   <= NIL;
            now_reg    <= '0;
            ov_reg     <= 1'b0;
            nf_reg     <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            queued_reg <= queued_next;
            fired_reg  <= fired_next;
            head_reg   <= head_next;
            now_reg    <= now_next;
            ov_reg     <= ov_next;
            nf_reg     <= nf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;  s_reg   <= s_next;   tv_reg  <= tv_next;
        per_reg <= per_next; key_reg <= key_next; cur_reg <= cur_next;
        prv_reg <= prv_next; stp_reg <= stp_next; fdl_reg <= fdl_next;
        ok_reg  <= ok_next;  oid_reg <= oid_next; op_pend_reg <= op_pend_next;
        odl_reg <= odl_next; ot_reg  <= ot_next;  ol_reg  <= ol_next;
    end

    assign ready          = (st_reg == ST_IDLE) && !ov_reg;
    assign result_valid   = ov_reg;
    assign result_kind    = ok_reg;
    assign slot_id        = oid_reg;
    assign slot_pending   = op_pend_reg;
    assign fired_deadline = odl_reg;
    assign current_time   = ot_reg;
    assign last           = ol_reg;

    logic cur_valid;
    assign cur_valid = (cur_reg < NIL) && (stp_reg < CW'(ENTRIES));

    always_comb
    begin
        st_next = st_reg; queued_next = queued_reg; fired_next = fired_reg;
        head_next = head_reg; now_next = now_reg; nf_next = nf_reg;
        op_next = op_reg; s_next = s_reg; tv_next = tv_reg; per_next = per_reg;
        key_next = key_reg; cur_next = cur_reg; prv_next = prv_reg;
        stp_next = stp_reg; fdl_next = fdl_reg;
        ov_next = ov_reg; ok_next = ok_reg; oid_next = oid_reg;
        op_pend_next = op_pend_reg; odl_next = odl_reg; ot_next = ot_reg;
        ol_next = ol_reg;
        rd_addr = cur_reg[IW-1:0];
        we_dp = 1'b0; wa_dp = s_reg; wd_dl = '0; wd_per = '0;
        we_nx = 1'b0; wa_nx = s_reg; wd_nx = NIL;
        emit_fire = 1'b0; emit_last = 1'b0;

        // drop the result once taken
        if (ov_reg && result_ready)
            ov_next = 1'b0;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (valid && ready)
                begin
                    op_next  = operation;
                    s_next   = IW'(entry_index);
                    tv_next  = time_value;
                    per_next = repeat_period;
                    if (operation <= 3'(OP_QUERY))
                    begin
                        if ({28'd0, entry_index} >= 32'(ENTRIES))
                        begin
                            // out-of-range slot: plain acknowledgement
                            ov_next = 1'b1; ok_next = 1'b0;
                            oid_next = entry_index; op_pend_next = 1'b0;
                            odl_next = '0; ot_next = now_reg; ol_next = 1'b1;
                        end
                        else if (operation == 3'(OP_QUERY))
                        begin
                            ov_next = 1'b1; ok_next = 1'b0;
                            oid_next = entry_index;
                            op_pend_next = queued_reg[IW'(entry_index)];
                            odl_next = '0; ot_next = now_reg; ol_next = 1'b1;
                        end
                        else
                        begin
                            cur_next = head_reg; prv_next = NIL; stp_next = '0;
                            st_next = ST_RM_RD;
                        end
                    end
                    else if (operation == 3'(OP_TICK))
                    begin
                        now_next = now_reg + 64'd1;
                        fired_next = '0;
                        nf_next = '0;
                        cur_next = head_reg; stp_next = '0;
                        st_next = ST_TK_RD;
                    end
                end
            end

            // unlink slot s: walk to it
            ST_RM_RD:
            begin
                if (!queued_reg[s_reg] || !cur_valid)
                begin
                    queued_next[s_reg] = 1'b0;
                    st_next = ST_WR_SLOT;
                end
                else
                    st_next = ST_RM_CHK;
            end
            ST_RM_CHK:
            begin
                if (cur_reg[IW-1:0] == s_reg)
                begin
                    if (prv_reg == NIL)
                        head_next = rd_nx;
                    else
                    begin
                        we_nx = 1'b1; wa_nx = prv_reg[IW-1:0]; wd_nx = rd_nx;
                    end
                    queued_next[s_reg] = 1'b0;
                    st_next = ST_RM_PRV;
                end
                else
                begin
                    prv_next = cur_reg; cur_next = rd_nx;
                    stp_next = stp_reg + 1'b1;
                    st_next = ST_RM_RD;
                end
            end
            ST_RM_PRV:
                st_next = ST_WR_SLOT;

            // write deadline and period, then insert or ack
            ST_WR_SLOT:
            begin
                we_dp = 1'b1; wa_dp = s_reg;
                if (op_reg == 3'(OP_SCHED_ABS))
                begin
                    wd_dl = tv_reg; wd_per = '0; key_next = tv_reg;
                end
                else if (op_reg == 3'(OP_SCHED_REL))
                begin
                    wd_dl = now_reg + tv_reg; wd_per = per_reg;
                    key_next = now_reg + tv_reg;
                end
                if (op_reg == 3'(OP_CANCEL))
                    st_next = ST_ACK;
                else
                begin
                    cur_next = head_reg; prv_next = NIL; stp_next = '0;
                    st_next = ST_IN_RD;
                end
            end

            // sorted insert of slot s with key_reg
            ST_IN_RD:
            begin
                if (!cur_valid)
                    st_next = ST_IN_LNK;
                else
                    st_next = ST_IN_CHK;
            end
            ST_IN_CHK:
            begin
                if (rd_dl <= key_reg)
                begin
                    prv_next = cur_reg; cur_next = rd_nx;
                    stp_next = stp_reg + 1'b1;
                    st_next = ST_IN_RD;
                end
                else
                    st_next = ST_IN_LNK;
            end
            ST_IN_LNK:
            begin
                we_nx = 1'b1; wa_nx = s_reg; wd_nx = cur_reg;
                queued_next[s_reg] = 1'b1;
                if (prv_reg == NIL)
                    head_next = LW'(s_reg);
                if (prv_reg != NIL)
                begin
                    // second link write next cycle
                    st_next = ST_TK_NEXT;
                end
                else
                    st_next = (op_reg == 3'(OP_TICK)) ? ST_OUT : ST_ACK;
            end
            ST_TK_NEXT:
            begin
                we_nx = 1'b1; wa_nx = prv_reg[IW-1:0]; wd_nx = LW'(s_reg);
                st_next = (op_reg == 3'(OP_TICK)) ? ST_OUT : ST_ACK;
            end

            ST_ACK:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1; ok_next = 1'b0;
                    oid_next = 4'(s_reg); op_pend_next = queued_reg[s_reg];
                    odl_next = '0; ot_next = now_reg; ol_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end

            // tick: find first due, unfired slot
            ST_TK_RD:
            begin
                if (!cur_valid || nf_reg == FW'(MAX_FIRES))
                begin
                    // release the held fire as the final result
                    if (nf_reg == '0)
                        st_next = ST_IDLE;
                    else if (!ov_reg)
                    begin
                        emit_fire = 1'b1; emit_last = 1'b1;
                        st_next = ST_IDLE;
                    end
                end
                else
                    st_next = ST_TK_CHK;
            end
            ST_TK_CHK:
            begin
                if (rd_dl > now_reg)
                begin
                    if (nf_reg == '0)
                        st_next = ST_IDLE;
                    else if (!ov_reg)
                    begin
                        emit_fire = 1'b1; emit_last = 1'b1;
                        st_next = ST_IDLE;
                    end
                end
                else if (!fired_reg[cur_reg[IW-1:0]])
                begin
                    // hold until the previous fire can go out
                    if (nf_reg == '0 || !ov_reg)
                    begin
                        emit_fire = (nf_reg != '0);
                        s_next = cur_reg[IW-1:0];
                        fdl_next = rd_dl;
                        key_next = rd_dl + rd_per;
                        per_next = rd_per;
                        fired_next[cur_reg[IW-1:0]] = 1'b1;
                        cur_next = head_reg; prv_next = NIL; stp_next = '0;
                        st_next = ST_FIRE;
                    end
                end
                else
                begin
                    cur_next = rd_nx; stp_next = stp_reg + 1'b1;
                    st_next = ST_TK_RD;
                end
            end
            ST_FIRE:
            begin
                // reuse unlink walk; op_reg stays tick
                st_next = ST_RM_RD;
            end
            ST_OUT:
            begin
                // count the fire and search for the next one
                nf_next = nf_reg + 1'b1;
                cur_next = head_reg; stp_next = '0;
                st_next = ST_TK_RD;
            end
            default:
                st_next = ST_IDLE;
        endcase

        // tick path after unlink: rewrite slot, reinsert if periodic
        if (st_reg == ST_WR_SLOT && op_reg == 3'(OP_TICK))
        begin
            we_dp = 1'b1; wa_dp = s_reg;
            wd_per = per_reg;
            if (per_reg != '0)
            begin
                wd_dl = key_reg;
                cur_next = head_reg; prv_next = NIL; stp_next = '0;
                st_next = ST_IN_RD;
            end
            else
            begin
                wd_dl = '0;
                st_next = ST_OUT;
            end
        end

        // load the held fire into the output register
        if (emit_fire)
        begin
            ov_next = 1'b1; ok_next = 1'b1;
            oid_next = 4'(s_reg); op_pend_next = queued_reg[s_reg];
            odl_next = fdl_reg; ot_next = now_reg; ol_next = emit_last;
        end
    end
endmodule
`default_nettype wire

// ----- sv/dcs_checker.sv -----
`default_nettype none
module dcs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        valid,
    input wire logic        ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic        result_kind,
    input wire logic        last,
    input wire logic [63:0] fired_deadline,
    input wire logic [63:0] current_time
);
    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");
    // no new request while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !ready)
        else $error("ready during pending result");
    // acknowledgements carry no deadline and end the request
    a_ack: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_kind |-> fired_deadline == 64'd0 && last)
        else $error("malformed acknowledgement");
    // a fire is never for a future deadline
    a_due: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind |-> fired_deadline <= current_time)
        else $error("bad fire");
endmodule

bind deadline_callout_scheduler dcs_checker u_dcs_checker (
    .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready),
    .result_valid(result_valid), .result_ready(result_ready),
    .result_kind(result_kind), .last(last),
    .fired_deadline(fired_deadline), .current_time(current_time)
);
`default_nettype wire
